[sv/ofs_pkg.sv]
// Shared types and constants of the output feedback supervisor.
package ofs_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_IDX_W   = $clog2(CHANNELS);
  localparam int CH_W       = 4;
  localparam int MASK_W     = 16;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] DELAY_RESET = TICK_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_CHECK_MASK    = 3'd0,
    REG_OFF_CHECK_MASK   = 3'd1,
    REG_TIMEOUT_OFF_MASK = 3'd2,
    REG_ON_DELAY         = 3'd3,
    REG_OFF_DELAY        = 3'd4
  } ofs_reg_e;

  typedef struct packed {
    logic              level;
    logic [TICK_W-1:0] tick;
  } ofs_entry_t;

endpackage

[sv/ofs_chan_store.sv]
// Per-channel state memory with reset valid bits and write-to-read forwarding.
module ofs_chan_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [ofs_pkg::CH_IDX_W-1:0] rd_idx_i,
  input  logic                         wr_en_i,
  input  logic [ofs_pkg::CH_IDX_W-1:0] wr_idx_i,
  input  ofs_pkg::ofs_entry_t          wr_data_i,
  output ofs_pkg::ofs_entry_t          rd_data_o
);

  ofs_pkg::ofs_entry_t mem [ofs_pkg::CHANNELS];

  logic [ofs_pkg::CHANNELS-1:0] vld_q, vld_d;
  ofs_pkg::ofs_entry_t          rd_q;
  logic                         rd_vld_q;
  logic                         fwd_hit_q;
  ofs_pkg::ofs_entry_t          fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_idx_i];
      fwd_q <= wr_data_i;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (wr_en_i) begin
      vld_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_idx_i];
        fwd_hit_q <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

[sv/output_feedback_supervisor.sv]
// Top level of the output feedback supervisor: config registers, update stage, result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_ready_o   | channel, command_level, feedback, link_error, now
//  out     | out       | out_valid_o / out_ready_i | out_channel, drive, on_error, off_error
//
// One request per cycle unless the input stalls; a request goes through the update stage, then the result register.
// The state memory is read in the accept cycle and written back by the update stage,
// with forwarding when consecutive requests address the same channel.
// Reset clears the valid bits at once, so no clearing pass is needed.
// A stalled result holds the update stage; the input stalls only when both are full.
module output_feedback_supervisor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ofs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ofs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ofs_pkg::CH_W-1:0]       channel_i,
  input  logic                           command_level_i,
  input  logic                           feedback_i,
  input  logic                           link_error_i,
  input  logic [ofs_pkg::TICK_W-1:0]     now_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ofs_pkg::CH_W-1:0]       out_channel_o,
  output logic                           drive_o,
  output logic                           on_error_o,
  output logic                           off_error_o
);

  logic [ofs_pkg::MASK_W-1:0] on_mask_q, off_mask_q, tmo_mask_q;
  logic [ofs_pkg::TICK_W-1:0] on_delay_q, off_delay_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_mask_q   <= '0;
      off_mask_q  <= '0;
      tmo_mask_q  <= '0;
      on_delay_q  <= ofs_pkg::DELAY_RESET;
      off_delay_q <= ofs_pkg::DELAY_RESET;
    end else if (cfg_valid_i) begin
      unique case (ofs_pkg::ofs_reg_e'(cfg_index_i))
        ofs_pkg::REG_ON_CHECK_MASK:    on_mask_q   <= cfg_data_i[ofs_pkg::MASK_W-1:0];
        ofs_pkg::REG_OFF_CHECK_MASK:   off_mask_q  <= cfg_data_i[ofs_pkg::MASK_W-1:0];
        ofs_pkg::REG_TIMEOUT_OFF_MASK: tmo_mask_q  <= cfg_data_i[ofs_pkg::MASK_W-1:0];
        ofs_pkg::REG_ON_DELAY:         on_delay_q  <= cfg_data_i[ofs_pkg::TICK_W-1:0];
        ofs_pkg::REG_OFF_DELAY:        off_delay_q <= cfg_data_i[ofs_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // update stage
  logic                       s1_vld_q;
  logic [ofs_pkg::CH_W-1:0]   s1_ch_q;
  logic                       s1_cmd_q, s1_fb_q, s1_link_q;
  logic [ofs_pkg::TICK_W-1:0] s1_now_q;

  logic out_vld_q;
  logic s1_adv, in_acc;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q   <= channel_i;
      s1_cmd_q  <= command_level_i;
      s1_fb_q   <= feedback_i;
      s1_link_q <= link_error_i;
      s1_now_q  <= now_i;
    end
  end

  logic [31:0]                  in_ch_ext, s1_ch_ext;
  logic [ofs_pkg::CH_IDX_W-1:0] rd_idx, wr_idx;
  logic                         s1_in_range;
  ofs_pkg::ofs_entry_t          entry, wr_entry;
  logic                         wr_en;

  assign in_ch_ext   = 32'(channel_i);
  assign s1_ch_ext   = 32'(s1_ch_q);
  assign rd_idx      = in_ch_ext[ofs_pkg::CH_IDX_W-1:0];
  assign wr_idx      = s1_ch_ext[ofs_pkg::CH_IDX_W-1:0];
  assign s1_in_range = s1_ch_ext < 32'(ofs_pkg::CHANNELS);
  assign wr_en       = s1_adv && s1_in_range;

  ofs_chan_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_entry),
    .rd_data_o (entry)
  );

  logic [ofs_pkg::TICK_W-1:0] elapsed;
  logic                       drive_d, on_err_d, off_err_d;

  always_comb begin
    wr_entry.level = s1_cmd_q;
    wr_entry.tick  = (s1_cmd_q != entry.level) ? s1_now_q : entry.tick;
    elapsed        = s1_now_q - wr_entry.tick;
    drive_d        = s1_in_range && s1_cmd_q && !(s1_link_q && tmo_mask_q[s1_ch_q]);
    on_err_d       = drive_d && on_mask_q[s1_ch_q] && (elapsed >= on_delay_q) && !s1_fb_q;
    off_err_d      = s1_in_range && !drive_d && off_mask_q[s1_ch_q]
                     && (elapsed >= off_delay_q) && s1_fb_q;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_channel_o <= s1_ch_q;
      drive_o       <= drive_d;
      on_error_o    <= on_err_d;
      off_error_o   <= off_err_d;
    end
  end

  assign out_valid_o = out_vld_q;

  a_on_err_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_error_o |-> drive_o)
    else $error("on-error without drive");

  a_off_err_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && off_error_o |-> !drive_o)
    else $error("off-error with drive");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && out_vld_q && !out_ready_i |-> !in_ready_o && !wr_en)
    else $error("request taken or state written while full");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("update stage advanced without a result");

endmodule

[verif/output_feedback_supervisor_test.sv]
// Self-checking testbench of the output feedback supervisor: directed and random channel updates.
module output_feedback_supervisor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [ofs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [ofs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ofs_pkg::CH_W-1:0]   channel;
    logic                       command_level;
    logic                       feedback;
    logic                       link_error;
    logic [ofs_pkg::TICK_W-1:0] now;
  } request_t;

  typedef struct packed {
    logic [ofs_pkg::CH_W-1:0] channel;
    logic                     drive;
    logic                     on_error;
    logic                     off_error;
  } result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [ofs_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [ofs_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [ofs_pkg::CH_W-1:0]       channel_i;
  logic                           command_level_i;
  logic                           feedback_i;
  logic                           link_error_i;
  logic [ofs_pkg::TICK_W-1:0]     now_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [ofs_pkg::CH_W-1:0]       out_channel_o;
  logic                           drive_o;
  logic                           on_error_o;
  logic                           off_error_o;

  logic [ofs_pkg::MASK_W-1:0] on_mask_q;
  logic [ofs_pkg::MASK_W-1:0] off_mask_q;
  logic [ofs_pkg::MASK_W-1:0] timeout_mask_q;
  logic [ofs_pkg::TICK_W-1:0] on_delay_q;
  logic [ofs_pkg::TICK_W-1:0] off_delay_q;
  logic                       level_q  [ofs_pkg::CHANNELS];
  logic [ofs_pkg::TICK_W-1:0] change_q [ofs_pkg::CHANNELS];

  result_t                    expected_results [$];
  int unsigned                mismatch_count = 0;
  int unsigned                cycle_count    = 0;
  int unsigned                send_idle_pct  = 0;
  int unsigned                ready_idle_pct = 0;
  logic [ofs_pkg::TICK_W-1:0] tick_now       = '0;
  bit                         offering       = 1'b0;

  output_feedback_supervisor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .channel_i      (channel_i),
    .command_level_i(command_level_i),
    .feedback_i     (feedback_i),
    .link_error_i   (link_error_i),
    .now_i          (now_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_channel_o  (out_channel_o),
    .drive_o        (drive_o),
    .on_error_o     (on_error_o),
    .off_error_o    (off_error_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= ready_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_result('{out_channel_o, drive_o, on_error_o, off_error_o});
    end
  end

  function automatic void clear_predictor();
    on_mask_q      = '0;
    off_mask_q     = '0;
    timeout_mask_q = '0;
    on_delay_q     = ofs_pkg::DELAY_RESET;
    off_delay_q    = ofs_pkg::DELAY_RESET;
    for (int c = 0; c < ofs_pkg::CHANNELS; c++) begin
      level_q[c]  = 1'b0;
      change_q[c] = '0;
    end
  endfunction

  function automatic void store_register(logic [ofs_pkg::CFG_IDX_W-1:0] idx,
                                         logic [ofs_pkg::CFG_DATA_W-1:0] data);
    unique case (idx)
      ofs_pkg::REG_ON_CHECK_MASK:    on_mask_q      = data[ofs_pkg::MASK_W-1:0];
      ofs_pkg::REG_OFF_CHECK_MASK:   off_mask_q     = data[ofs_pkg::MASK_W-1:0];
      ofs_pkg::REG_TIMEOUT_OFF_MASK: timeout_mask_q = data[ofs_pkg::MASK_W-1:0];
      ofs_pkg::REG_ON_DELAY:         on_delay_q     = data[ofs_pkg::TICK_W-1:0];
      ofs_pkg::REG_OFF_DELAY:        off_delay_q    = data[ofs_pkg::TICK_W-1:0];
      default: ;
    endcase
  endfunction

  // Change detection follows the commanded level, so a forced-off drive keeps the change tick.
  function automatic result_t predict_channel(request_t req);
    result_t                    res;
    logic [ofs_pkg::TICK_W-1:0] elapsed;
    res         = '0;
    res.channel = req.channel;
    if (int'(req.channel) < ofs_pkg::CHANNELS) begin
      if (req.command_level != level_q[req.channel]) begin
        level_q[req.channel]  = req.command_level;
        change_q[req.channel] = req.now;
      end
      res.drive = req.command_level && !(req.link_error && timeout_mask_q[req.channel]);
      elapsed   = req.now - change_q[req.channel];
      if (res.drive) begin
        res.on_error = on_mask_q[req.channel] && (elapsed >= on_delay_q) && !req.feedback;
      end else begin
        res.off_error = off_mask_q[req.channel] && (elapsed >= off_delay_q) && req.feedback;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result for channel %0d", got.channel));
    end else begin
      want = expected_results.pop_front();
      if (got.channel !== want.channel)
        report_mismatch($sformatf("out_channel %0d, want %0d", got.channel, want.channel));
      if (got.drive !== want.drive)
        report_mismatch($sformatf("ch %0d drive %b, want %b", want.channel, got.drive,
                                  want.drive));
      if (got.on_error !== want.on_error)
        report_mismatch($sformatf("ch %0d on_error %b, want %b", want.channel, got.on_error,
                                  want.on_error));
      if (got.off_error !== want.off_error)
        report_mismatch($sformatf("ch %0d off_error %b, want %b", want.channel, got.off_error,
                                  want.off_error));
    end
  endtask

  task automatic send_request(request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    offering = 1'b1;
    channel_i       <= req.channel;
    command_level_i <= req.command_level;
    feedback_i      <= req.feedback;
    link_error_i    <= req.link_error;
    now_i           <= req.now;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_channel(req));
  endtask

  task automatic wait_results_drained();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Write every register in turn, preceded by a write to an unused index.
  task automatic program_registers(logic [ofs_pkg::CFG_DATA_W-1:0] on_m,
                                   logic [ofs_pkg::CFG_DATA_W-1:0] off_m,
                                   logic [ofs_pkg::CFG_DATA_W-1:0] to_m,
                                   logic [ofs_pkg::CFG_DATA_W-1:0] on_d,
                                   logic [ofs_pkg::CFG_DATA_W-1:0] off_d);
    logic [ofs_pkg::CFG_IDX_W-1:0]  idx [6];
    logic [ofs_pkg::CFG_DATA_W-1:0] val [6];
    idx = '{ofs_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
            ofs_pkg::REG_ON_CHECK_MASK, ofs_pkg::REG_OFF_CHECK_MASK,
            ofs_pkg::REG_TIMEOUT_OFF_MASK, ofs_pkg::REG_ON_DELAY, ofs_pkg::REG_OFF_DELAY};
    val = '{ofs_pkg::CFG_DATA_W'($urandom), on_m, off_m, to_m, on_d, off_d};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      store_register(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Favour a few channels and mostly hold the level, so delays run out between changes.
  function automatic request_t random_request();
    request_t req;
    req.channel       = ($urandom_range(99) < 40) ? ofs_pkg::CH_W'($urandom_range(3))
                                                  : ofs_pkg::CH_W'($urandom);
    req.command_level = ($urandom_range(99) < 25) ? !level_q[req.channel] : level_q[req.channel];
    req.feedback      = ($urandom_range(99) < 25) ? !req.command_level : req.command_level;
    req.link_error    = ($urandom_range(99) < 15);
    if ($urandom_range(99) < 3) begin
      tick_now = ofs_pkg::TICK_W'($urandom);
    end else begin
      tick_now = tick_now + ofs_pkg::TICK_W'($urandom_range(12));
    end
    req.now = tick_now;
    return req;
  endfunction

  task automatic test_reset_defaults();
    send_request('{4'd0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF});
    send_request('{4'd15, 1'b0, 1'b1, 1'b1, 32'h0000_0000});
  endtask

  task automatic test_feedback_delays();
    wait_results_drained();
    program_registers(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'd10, 32'd10);
    send_request('{4'd1, 1'b1, 1'b0, 1'b0, 32'd100});
    send_request('{4'd1, 1'b1, 1'b0, 1'b0, 32'd109});
    send_request('{4'd1, 1'b1, 1'b0, 1'b0, 32'd110});
    send_request('{4'd1, 1'b1, 1'b1, 1'b0, 32'd110});
    send_request('{4'd1, 1'b0, 1'b1, 1'b0, 32'd200});
    send_request('{4'd1, 1'b0, 1'b1, 1'b0, 32'd210});
    send_request('{4'd1, 1'b0, 1'b0, 1'b0, 32'd210});
  endtask

  task automatic test_forced_off();
    send_request('{4'd2, 1'b1, 1'b1, 1'b0, 32'd300});
    send_request('{4'd2, 1'b1, 1'b1, 1'b1, 32'd320});
    send_request('{4'd2, 1'b1, 1'b0, 1'b0, 32'd321});
  endtask

  task automatic test_tick_wrap();
    send_request('{4'd3, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFA});
    send_request('{4'd3, 1'b1, 1'b0, 1'b0, 32'd3});
    send_request('{4'd3, 1'b1, 1'b0, 1'b0, 32'd4});
  endtask

  task automatic test_delay_extremes();
    wait_results_drained();
    program_registers(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0000, 32'd0, 32'd0);
    send_request('{4'd4, 1'b1, 1'b0, 1'b0, 32'd5});
    wait_results_drained();
    program_registers(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
    send_request('{4'd4, 1'b1, 1'b0, 1'b1, 32'd4});
    send_request('{4'd5, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF});
    send_request('{4'd5, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFE});
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned send_idle,
                                     int unsigned ready_idle,
                                     logic [ofs_pkg::CFG_DATA_W-1:0] on_m,
                                     logic [ofs_pkg::CFG_DATA_W-1:0] off_m,
                                     logic [ofs_pkg::CFG_DATA_W-1:0] to_m,
                                     logic [ofs_pkg::CFG_DATA_W-1:0] on_d,
                                     logic [ofs_pkg::CFG_DATA_W-1:0] off_d);
    wait_results_drained();
    program_registers(on_m, off_m, to_m, on_d, off_d);
    send_idle_pct  = send_idle;
    ready_idle_pct = ready_idle;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_results_drained();
      end
      send_request(random_request());
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= ofs_pkg::REG_ON_CHECK_MASK;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    channel_i       <= '0;
    command_level_i <= 1'b0;
    feedback_i      <= 1'b0;
    link_error_i    <= 1'b0;
    now_i           <= '0;
    out_ready_i     <= 1'b0;
    clear_predictor();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct  = 20;
    ready_idle_pct = 88;

    test_reset_defaults();
    test_feedback_delays();
    test_forced_off();
    test_tick_wrap();
    test_delay_extremes();

    test_random_traffic(700, 20, 88, $urandom, $urandom, $urandom,
                        $urandom_range(60), $urandom_range(60));
    test_random_traffic(700, 88, 20, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_0000,
                        32'd0, $urandom_range(1, 60));
    tick_now = 32'hFFFF_FF00;
    test_random_traffic(600, 0, 0, $urandom, $urandom, 32'hFFFF_FFFF,
                        $urandom_range(60), $urandom_range(60));

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
